>>> rtl/gbce_pkg.sv
// Package for the GF(32) BCH checksum engine: beat types, command codes,
// generator and target tables, and the GF(32) multiply and residue compare.
// No dependencies.
`default_nettype none

package gbce_pkg;

    typedef logic [4:0] sym_t;
    typedef logic [3:0] pos_t;
    typedef sym_t res_arr_t [15];

    localparam int NumPos = 15;

    localparam logic [1:0] CMD_START    = 2'd0;
    localparam logic [1:0] CMD_FEED     = 2'd1;
    localparam logic [1:0] CMD_FINALIZE = 2'd2;
    localparam logic [1:0] CMD_NONE     = 2'd3;

    localparam pos_t LAST_SHORT = 4'd12;
    localparam pos_t LAST_LONG  = 4'd14;

    localparam sym_t GEN_SHORT [15] = '{
        5'd25, 5'd27, 5'd17, 5'd8, 5'd0, 5'd25, 5'd25, 5'd25,
        5'd31, 5'd27, 5'd24, 5'd16, 5'd16, 5'd0, 5'd0};
    localparam sym_t GEN_LONG [15] = '{
        5'd15, 5'd10, 5'd25, 5'd26, 5'd9, 5'd25, 5'd21, 5'd6,
        5'd23, 5'd21, 5'd6, 5'd5, 5'd22, 5'd4, 5'd23};
    localparam sym_t TGT_SHORT [15] = '{
        5'd16, 5'd25, 5'd24, 5'd3, 5'd25, 5'd11, 5'd16, 5'd23,
        5'd29, 5'd3, 5'd25, 5'd17, 5'd10, 5'd0, 5'd0};
    localparam sym_t TGT_LONG [15] = '{
        5'd16, 5'd25, 5'd24, 5'd3, 5'd25, 5'd11, 5'd16, 5'd23,
        5'd29, 5'd3, 5'd25, 5'd17, 5'd10, 5'd25, 5'd6};

    typedef struct packed {
        logic [1:0] command;
        logic [4:0] symbol;
        logic       long_code;
    } in_beat_t;

    typedef struct packed {
        logic [4:0] checksum_symbol;
        logic       residue_matches;
        logic       last_of_run;
    } out_beat_t;

    typedef struct packed {
        logic load_init;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_ABSORB,
        ST_EMIT
    } state_t;

    // Multiplication in GF(32) with reduction polynomial x^5 + x^3 + 1.
    function automatic sym_t gf_mul(input sym_t a, input sym_t b);
        logic [5:0] x;
        sym_t       acc;
        acc = '0;
        x   = {1'b0, a};
        for (int k = 0; k < 5; k++) begin
            if (b[k]) begin
                acc = acc ^ x[4:0];
            end
            x = {x[4:0], 1'b0};
            if (x[5]) begin
                x = x ^ 6'b101001;
            end
        end
        return acc;
    endfunction

    function automatic logic residue_match(input res_arr_t res, input logic lng);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NumPos; i++) begin
            if ((i < 13 || lng) && res[i] != (lng ? TGT_LONG[i] : TGT_SHORT[i])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gf32_bch_checksum_engine.sv
// Start, feed and unused commands: one result beat registered in the cycle after the
// input beat, and a new input beat is taken every cycle while results flow.
// Finalize: the 13 (short) or 15 (long) target symbols are absorbed through the cell
// chain, then one checksum beat per cycle while output is free; input is held off.
// Reset: residue takes the short-code initial value at once, no clearing pass.
`default_nettype none

module gf32_bch_checksum_engine (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire gbce_pkg::in_beat_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output gbce_pkg::out_beat_t     m_data
);
    import gbce_pkg::*;

    state_t    state_reg, state_next;
    pos_t      cnt_reg, cnt_next;
    logic      long_reg, long_next;
    logic      m_valid_reg, m_valid_next;
    out_beat_t m_data_reg, m_data_next;

    res_arr_t   res, res_nx;
    cell_ctrl_t ctrl;
    sym_t       abs_sym;
    pos_t       last_idx;
    pos_t       init_last;
    logic       s_fire;
    logic       out_free;
    logic       match_nx;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_RUN) && out_free;
    assign s_fire    = s_valid && s_ready;
    assign last_idx  = long_reg ? LAST_LONG : LAST_SHORT;
    assign init_last = s_data.long_code ? LAST_LONG : LAST_SHORT;
    assign abs_sym   = (state_reg == ST_ABSORB)
                       ? (long_reg ? TGT_LONG[cnt_reg] : TGT_SHORT[cnt_reg])
                       : s_data.symbol;

    always_comb begin
        ctrl.load_init = s_fire && s_data.command == CMD_START;
        ctrl.shift     = (s_fire && s_data.command == CMD_FEED) || state_reg == ST_ABSORB;
    end

    for (genvar i = 0; i < NumPos; i++) begin : g_cell
        sym_t shift_in;
        if (i == 14) begin : g_tail
            assign shift_in = long_reg ? abs_sym : '0;
        end else if (i == 12) begin : g_short_tail
            assign shift_in = long_reg ? res[13] : abs_sym;
        end else begin : g_mid
            assign shift_in = res[i+1];
        end

        gbce_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .reset_sym ((i == 12) ? 5'd1 : 5'd0),
            .init_sym  ((pos_t'(i) == init_last) ? 5'd1 : 5'd0),
            .gen_coef  (long_reg ? GEN_LONG[i] : GEN_SHORT[i]),
            .head      (res[0]),
            .shift_in  (shift_in),
            .sym       (res[i]),
            .sym_next  (res_nx[i])
        );
    end

    assign match_nx = residue_match(res_nx, ctrl.load_init ? s_data.long_code : long_reg);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        long_next    = long_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            ST_RUN: begin
                if (s_fire) begin
                    case (s_data.command)
                        CMD_START: begin
                            long_next = s_data.long_code;
                        end
                        CMD_FINALIZE: begin
                            state_next = ST_ABSORB;
                            cnt_next   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ABSORB: begin
                if (cnt_reg == last_idx) begin
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (cnt_reg == last_idx) begin
                        state_next = ST_RUN;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase

        if (s_fire && s_data.command != CMD_FINALIZE) begin
            m_valid_next                = 1'b1;
            m_data_next.checksum_symbol = '0;
            m_data_next.residue_matches = match_nx;
            m_data_next.last_of_run     = 1'b1;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_valid_next                = 1'b1;
            m_data_next.checksum_symbol = res[cnt_reg];
            m_data_next.residue_matches = match_nx;
            m_data_next.last_of_run     = (cnt_reg == last_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            cnt_reg     <= '0;
            long_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            long_reg    <= long_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_short_tail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !long_reg |-> (res[13] == '0 && res[14] == '0))
        else $error("Unused residue cells are not zero in short code.");

    a_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_RUN |-> cnt_reg <= last_idx)
        else $error("Finalize counter is beyond the code length.");

    a_absorb_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ABSORB && cnt_reg == last_idx)
        |=> (state_reg == ST_EMIT && cnt_reg == '0))
        else $error("Absorption did not hand over to emission.");

    a_emit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && cnt_reg == last_idx)
        |=> (state_reg == ST_RUN && m_valid_reg && m_data_reg.last_of_run))
        else $error("Final checksum beat is not marked last.");

    a_no_input_in_finalize: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_RUN |-> !s_ready)
        else $error("Input accepted during finalize.");
`endif

endmodule

`default_nettype wire

>>> rtl/gbce_cell.sv
// One residue cell of the checksum engine: holds a single GF(32) symbol and
// on a shift takes its neighbor's symbol plus the generator coefficient times the head.
// Depends on gbce_pkg.
`default_nettype none

module gbce_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire gbce_pkg::cell_ctrl_t ctrl,
    input  wire gbce_pkg::sym_t     reset_sym,
    input  wire gbce_pkg::sym_t     init_sym,
    input  wire gbce_pkg::sym_t     gen_coef,
    input  wire gbce_pkg::sym_t     head,
    input  wire gbce_pkg::sym_t     shift_in,
    output gbce_pkg::sym_t          sym,
    output gbce_pkg::sym_t          sym_next
);
    import gbce_pkg::*;

    sym_t sym_reg;

    always_comb begin
        if (ctrl.load_init) begin
            sym_next = init_sym;
        end else if (ctrl.shift) begin
            sym_next = shift_in ^ gf_mul(gen_coef, head);
        end else begin
            sym_next = sym_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_reg <= reset_sym;
        end else begin
            sym_reg <= sym_next;
        end
    end

    assign sym = sym_reg;

endmodule

`default_nettype wire

>>> sim/gf32_bch_checksum_engine_tb.sv
// Self-checking testbench for gf32_bch_checksum_engine: a directed table and random
// messages with finalize and codeword verify passes, checked against a residue predictor.
// Depends on gbce_pkg and the engine RTL.
`default_nettype none

module gf32_bch_checksum_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbce_pkg::*;

    localparam int ShortLen    = 13;
    localparam int LongLen     = 15;
    localparam int RandomItems = 264;
    localparam int HoldCycles  = 200;
    localparam int DrainCycles = 40;
    localparam int PlanLen     = 17;

    localparam sym_t GenShort [15] = '{
        5'd25, 5'd27, 5'd17, 5'd8, 5'd0, 5'd25, 5'd25, 5'd25,
        5'd31, 5'd27, 5'd24, 5'd16, 5'd16, 5'd0, 5'd0};
    localparam sym_t GenLong  [15] = '{
        5'd15, 5'd10, 5'd25, 5'd26, 5'd9, 5'd25, 5'd21, 5'd6,
        5'd23, 5'd21, 5'd6, 5'd5, 5'd22, 5'd4, 5'd23};
    localparam sym_t TgtShort [15] = '{
        5'd16, 5'd25, 5'd24, 5'd3, 5'd25, 5'd11, 5'd16, 5'd23,
        5'd29, 5'd3, 5'd25, 5'd17, 5'd10, 5'd0, 5'd0};
    localparam sym_t TgtLong  [15] = '{
        5'd16, 5'd25, 5'd24, 5'd3, 5'd25, 5'd11, 5'd16, 5'd23,
        5'd29, 5'd3, 5'd25, 5'd17, 5'd10, 5'd25, 5'd6};

    typedef struct packed {
        in_beat_t  beat;
        logic      typed;
        out_beat_t want;
    } plan_row_t;

    localparam out_beat_t NoMatchDone = '{5'd0, 1'b0, 1'b1};

    localparam plan_row_t DirectedPlan [PlanLen] = '{
        '{'{CMD_NONE,     5'd31, 1'b1}, 1'b1, NoMatchDone},
        '{'{CMD_FEED,     5'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_FEED,     5'd31, 1'b0}, 1'b0, '0},
        '{'{CMD_FINALIZE, 5'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_FEED,     5'd21, 1'b0}, 1'b0, '0},
        '{'{CMD_START,    5'd31, 1'b1}, 1'b1, NoMatchDone},
        '{'{CMD_FEED,     5'd31, 1'b1}, 1'b0, '0},
        '{'{CMD_FEED,     5'd0,  1'b1}, 1'b0, '0},
        '{'{CMD_FEED,     5'd10, 1'b0}, 1'b0, '0},
        '{'{CMD_FEED,     5'd21, 1'b1}, 1'b0, '0},
        '{'{CMD_FINALIZE, 5'd31, 1'b1}, 1'b0, '0},
        '{'{CMD_NONE,     5'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_START,    5'd0,  1'b0}, 1'b1, NoMatchDone},
        '{'{CMD_FINALIZE, 5'd10, 1'b1}, 1'b0, '0},
        '{'{CMD_START,    5'd21, 1'b1}, 1'b1, NoMatchDone},
        '{'{CMD_FINALIZE, 5'd0,  1'b0}, 1'b0, '0},
        '{'{CMD_START,    5'd31, 1'b0}, 1'b1, NoMatchDone}
    };

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    sym_t      resid [15];
    logic      resid_long;
    sym_t      last_checksum [15];
    int        last_checksum_len;
    out_beat_t due_beats [$];
    int        mismatch_cnt  = 0;
    int        items_sent    = 0;
    int        idle_send_pct = 0;
    int        stall_recv_pct = 0;
    logic      hold_req      = 1'b0;
    logic      hold_done     = 1'b0;

    gf32_bch_checksum_engine dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #6_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Multiplication in GF(32) modulo x^5 + x^3 + 1.
    function automatic sym_t gf32_times(input sym_t a, input sym_t b);
        sym_t prod;
        sym_t x;
        prod = '0;
        x    = a;
        for (int k = 0; k < 5; k++) begin
            if (b[k]) begin
                prod ^= x;
            end
            x = x[4] ? ({x[3:0], 1'b0} ^ 5'b01001) : {x[3:0], 1'b0};
        end
        return prod;
    endfunction

    function automatic int code_length(input logic lng);
        return lng ? LongLen : ShortLen;
    endfunction

    function automatic void due_append(input out_beat_t b);
        due_beats = {due_beats, b};
    endfunction

    function automatic void residue_restart(input logic lng);
        resid_long = lng;
        foreach (resid[i]) begin
            resid[i] = '0;
        end
        resid[code_length(lng) - 1] = 5'd1;
    endfunction

    function automatic void residue_absorb(input sym_t s);
        int   n;
        sym_t head;
        n    = code_length(resid_long);
        head = resid[0];
        for (int i = 1; i < n; i++) begin
            resid[i - 1] = resid[i];
        end
        resid[n - 1] = s;
        for (int i = 0; i < n; i++) begin
            resid[i] ^= gf32_times(resid_long ? GenLong[i] : GenShort[i], head);
        end
    endfunction

    function automatic logic residue_on_target();
        for (int i = 0; i < code_length(resid_long); i++) begin
            if (resid[i] != (resid_long ? TgtLong[i] : TgtShort[i])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void absorb_and_report(input in_beat_t b, input logic keep);
        int   n;
        logic hit;
        n = code_length(resid_long);
        if (b.command == CMD_FINALIZE) begin
            for (int i = 0; i < n; i++) begin
                residue_absorb(resid_long ? TgtLong[i] : TgtShort[i]);
            end
            hit = residue_on_target();
            last_checksum_len = n;
            for (int i = 0; i < n; i++) begin
                last_checksum[i] = resid[i];
                if (keep) begin
                    due_append(out_beat_t'{resid[i], hit, i == n - 1});
                end
            end
        end else begin
            if (b.command == CMD_START) begin
                residue_restart(b.long_code);
            end else if (b.command == CMD_FEED) begin
                residue_absorb(b.symbol);
            end
            if (keep) begin
                due_append(out_beat_t'{5'd0, residue_on_target(), 1'b1});
            end
        end
    endfunction

    function automatic in_beat_t beat_of(input logic [1:0] cmd, input sym_t sym,
                                         input logic lng);
        return '{cmd, sym, lng};
    endfunction

    task automatic send_beat(input in_beat_t b, input logic typed_row = 1'b0,
                             input out_beat_t typed_want = '0);
        @(negedge aclk);
        while ($urandom_range(0, 99) < idle_send_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        absorb_and_report(b, !typed_row);
        if (typed_row) begin
            due_append(typed_want);
        end
        items_sent++;
    endtask

    task automatic send_message();
        sym_t body [$];
        logic lng;
        int   len;
        int   bad_pos;
        sym_t sym;
        lng = 1'($urandom_range(0, 1));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
            body = {body, sym_t'($urandom_range(0, 31))};
        end
        send_beat(beat_of(CMD_START, sym_t'($urandom_range(0, 31)), lng));
        foreach (body[i]) begin
            if ($urandom_range(0, 19) == 0) begin
                send_beat(beat_of(CMD_NONE, sym_t'($urandom_range(0, 31)),
                                  1'($urandom_range(0, 1))));
            end
            send_beat(beat_of(CMD_FEED, body[i], 1'($urandom_range(0, 1))));
        end
        send_beat(beat_of(CMD_FINALIZE, sym_t'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1))));
        if ($urandom_range(0, 99) < 60) begin
            // Replay the message followed by its checksum; most runs end on a match.
            bad_pos = ($urandom_range(0, 99) < 30) ? $urandom_range(0, last_checksum_len - 1) : -1;
            send_beat(beat_of(CMD_START, sym_t'($urandom_range(0, 31)), lng));
            foreach (body[i]) begin
                send_beat(beat_of(CMD_FEED, body[i], 1'($urandom_range(0, 1))));
            end
            for (int i = 0; i < last_checksum_len; i++) begin
                sym = last_checksum[i];
                if (i == bad_pos) begin
                    sym ^= sym_t'($urandom_range(1, 31));
                end
                send_beat(beat_of(CMD_FEED, sym, 1'($urandom_range(0, 1))));
            end
        end
    endtask

    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HoldCycles) @(negedge aclk);
                hold_done = 1'b1;
            end
            m_ready <= ($urandom_range(0, 99) >= stall_recv_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_beats.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("%0t: result beat with nothing due: sym=%0d match=%0d last=%0d",
                             $realtime, m_data.checksum_symbol, m_data.residue_matches,
                             m_data.last_of_run);
                end
            end else begin
                want = due_beats.pop_front();
                if (m_data.checksum_symbol !== want.checksum_symbol
                        || m_data.residue_matches !== want.residue_matches
                        || m_data.last_of_run !== want.last_of_run) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("%0t: expected sym=%0d match=%0d last=%0d", $realtime,
                                 want.checksum_symbol, want.residue_matches, want.last_of_run);
                        $display("%0t:      got sym=%0d match=%0d last=%0d", $realtime,
                                 m_data.checksum_symbol, m_data.residue_matches,
                                 m_data.last_of_run);
                    end
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        residue_restart(1'b0);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DirectedPlan[i]) begin
            send_beat(DirectedPlan[i].beat, DirectedPlan[i].typed, DirectedPlan[i].want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_send_pct  = 0;
                    stall_recv_pct = 0;
                    hold_req       = 1'b1;
                end
                1: begin
                    idle_send_pct  = 54;
                    stall_recv_pct = 0;
                end
                2: begin
                    idle_send_pct  = 0;
                    stall_recv_pct = 54;
                end
                default: begin
                    idle_send_pct  = 30;
                    stall_recv_pct = 30;
                end
            endcase
            while (items_sent < PlanLen + (ph + 1) * RandomItems / 4) begin
                if ($urandom_range(0, 99) < 80) begin
                    send_message();
                end else begin
                    send_beat(beat_of(2'($urandom_range(0, 3)), sym_t'($urandom_range(0, 31)),
                                      1'($urandom_range(0, 1))));
                end
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DrainCycles) @(posedge aclk);
        if (mismatch_cnt == 0 && due_beats.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
